// ----- src/cht_pkg.sv -----
// shared types and constants of the chained hash table engine
package cht_pkg;

  localparam int OP_W     = 2;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 7;

  // hash divide: four quotient bits per cycle over the 32-bit hash
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = WORD_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] BUCKET_COUNT_RST = CFG_W'(64);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd5;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_HEAD,
    B_RD,
    B_CMP,
    B_SLOT,
    B_LINK
  } back_state_t;

endpackage

// ----- src/cht_front.sv -----
// front end: accepts requests and reduces the hash to a bucket index
module cht_front #(
  parameter int BW = 6,
  parameter int KW = 32,
  parameter int VW = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [cht_pkg::CFG_W-1:0] div_i,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [cht_pkg::OP_W-1:0]  in_opcode,
  input  logic [cht_pkg::WORD_W-1:0] in_hash_value,
  input  logic [cht_pkg::WORD_W-1:0] in_key_word,
  input  logic [cht_pkg::WORD_W-1:0] in_value_word,
  output logic                      q_push,
  input  logic                      q_full,
  output logic [cht_pkg::OP_W+BW+KW+VW-1:0] q_data
);
  import cht_pkg::*;

  front_state_t         state_r, state_nxt;
  logic [OP_W-1:0]      op_r;
  logic [WORD_W-1:0]    hash_r, hash_nxt;
  logic [KW-1:0]        key_r;
  logic [VW-1:0]        val_r;
  logic [CFG_W-1:0]     div_r;
  logic [CFG_W-1:0]     rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 accept;

  assign in_full = (state_r != F_IDLE);
  assign accept  = in_push && !in_full;

  // restoring remainder, a few bits per cycle
  always_comb begin
    logic [CFG_W:0]    t;
    logic [CFG_W-1:0]  r;
    logic [WORD_W-1:0] h;
    r = rem_r;
    h = hash_r;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, h[WORD_W-1]};
      h = {h[WORD_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
      end
      r = t[CFG_W-1:0];
    end
    rem_nxt  = r;
    hash_nxt = h;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_DIV;
          cnt_nxt   = '0;
        end
      end
      F_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      hash_r <= in_hash_value;
      key_r  <= in_key_word[KW-1:0];
      val_r  <= in_value_word[VW-1:0];
      div_r  <= div_i;
      rem_r  <= '0;
    end else if (state_r == F_DIV) begin
      hash_r <= hash_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign q_data = {op_r, BW'(rem_r), key_r, val_r};

endmodule

// ----- src/cht_queue.sv -----
// two-entry queue between the front end and the table sequencer
module cht_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wdata;
  end

endmodule

// ----- src/cht_back.sv -----
// table sequencer: bucket heads, entry pool, chain walk and result register
module cht_back #(
  parameter int BUCKETS = 64,
  parameter int ENTRIES = 128,
  parameter int BW      = 6,
  parameter int KW      = 32,
  parameter int VW      = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cht_pkg::OP_W+BW+KW+VW-1:0] q_data,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [cht_pkg::STATUS_W-1:0] out_status,
  output logic [cht_pkg::WORD_W-1:0]   out_found_value
);
  import cht_pkg::*;

  localparam int IW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam logic [IW-1:0] NIL = IW'(ENTRIES);

  back_state_t    state_r, state_nxt;
  logic [OP_W-1:0] op_r;
  logic [BW-1:0]  bkt_r;
  logic [KW-1:0]  key_r;
  logic [VW-1:0]  val_r;
  logic [IW-1:0]  cur_r, cur_nxt;
  logic [IW-1:0]  prev_r, prev_nxt;
  logic [IW-1:0]  head_r, head_nxt;
  logic [IW-1:0]  slot_r, slot_nxt;
  logic [IW-1:0]  sp_r, sp_nxt;
  logic [IW-1:0]  fresh_r, fresh_nxt;
  logic [BUCKETS-1:0] hv_r;

  logic [OP_W-1:0] q_op;
  logic [BW-1:0]   q_bkt;
  logic [KW-1:0]   q_key;
  logic [VW-1:0]   q_val;

  logic [KW-1:0] key_mem  [ENTRIES];
  logic [VW-1:0] val_mem  [ENTRIES];
  logic [IW-1:0] link_mem [ENTRIES];
  logic [IW-1:0] head_mem [BUCKETS];
  logic [IW-1:0] stack_mem[ENTRIES];
  logic [KW-1:0] key_q;
  logic [VW-1:0] val_q;
  logic [IW-1:0] link_q, heads_q, stack_q;

  logic          key_we, val_we, link_we, head_we, stack_we, hv_set;
  logic [AW-1:0] key_wa, val_wa, link_wa;
  logic [VW-1:0] val_wd;
  logic [IW-1:0] link_wd, head_wd;

  logic                res_valid_r, res_set;
  logic [STATUS_W-1:0] res_status_r, res_status;
  logic [WORD_W-1:0]   res_value_r, res_value;

  assign {q_op, q_bkt, q_key, q_val} = q_data;
  assign q_pop = (state_r == B_IDLE) && !q_empty && !res_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    head_nxt   = head_r;
    slot_nxt   = slot_r;
    sp_nxt     = sp_r;
    fresh_nxt  = fresh_r;
    key_we     = 1'b0;
    val_we     = 1'b0;
    link_we    = 1'b0;
    head_we    = 1'b0;
    stack_we   = 1'b0;
    hv_set     = 1'b0;
    key_wa     = slot_r[AW-1:0];
    val_wa     = slot_r[AW-1:0];
    link_wa    = slot_r[AW-1:0];
    val_wd     = val_r;
    link_wd    = head_r;
    head_wd    = slot_r;
    res_set    = 1'b0;
    res_status = ST_NOT_FOUND;
    res_value  = '0;
    case (state_r)
      B_IDLE: begin
        if (q_pop) state_nxt = B_HEAD;
      end
      B_HEAD: begin
        head_nxt  = hv_r[bkt_r] ? heads_q : NIL;
        cur_nxt   = hv_r[bkt_r] ? heads_q : NIL;
        prev_nxt  = NIL;
        state_nxt = B_RD;
      end
      B_RD: begin
        if (cur_r == NIL) begin
          // end of chain: miss
          if (op_r == OP_INSERT && sp_r != '0) begin
            sp_nxt    = sp_r - 1'b1;
            state_nxt = B_SLOT;
          end else if (op_r == OP_INSERT && fresh_r != NIL) begin
            slot_nxt  = fresh_r;
            fresh_nxt = fresh_r + 1'b1;
            state_nxt = B_LINK;
          end else begin
            res_set    = 1'b1;
            res_status = (op_r == OP_INSERT) ? ST_POOL_FULL : ST_NOT_FOUND;
            state_nxt  = B_IDLE;
          end
        end else begin
          state_nxt = B_CMP;
        end
      end
      B_CMP: begin
        if (key_q == key_r) begin
          res_set   = 1'b1;
          state_nxt = B_IDLE;
          case (op_r)
            OP_INSERT: begin
              val_we     = 1'b1;
              val_wa     = cur_r[AW-1:0];
              res_status = ST_UPDATED;
            end
            OP_SEARCH: begin
              res_status = ST_FOUND;
              res_value  = WORD_W'(val_q);
            end
            OP_DELETE: begin
              if (prev_r == NIL) begin
                head_we = 1'b1;
                head_wd = link_q;
              end else begin
                link_we = 1'b1;
                link_wa = prev_r[AW-1:0];
                link_wd = link_q;
              end
              stack_we   = 1'b1;
              sp_nxt     = sp_r + 1'b1;
              res_status = ST_DELETED;
            end
            default: res_status = ST_NOT_FOUND;
          endcase
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = link_q;
          state_nxt = B_RD;
        end
      end
      B_SLOT: begin
        slot_nxt  = stack_q;
        state_nxt = B_LINK;
      end
      B_LINK: begin
        // new entry goes to the head of its chain
        key_we     = 1'b1;
        val_we     = 1'b1;
        link_we    = 1'b1;
        head_we    = 1'b1;
        hv_set     = 1'b1;
        res_set    = 1'b1;
        res_status = ST_INSERTED;
        state_nxt  = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sp_r        <= '0;
      fresh_r     <= '0;
      hv_r        <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      fresh_r <= fresh_nxt;
      if (hv_set) hv_r[bkt_r] <= 1'b1;
      if (res_set)      res_valid_r <= 1'b1;
      else if (out_pop) res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    head_r <= head_nxt;
    slot_r <= slot_nxt;
    if (q_pop) begin
      op_r  <= q_op;
      bkt_r <= q_bkt;
      key_r <= q_key;
      val_r <= q_val;
    end
    if (res_set) begin
      res_status_r <= res_status;
      res_value_r  <= res_value;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we)  key_mem[key_wa]   <= key_r;
    if (val_we)  val_mem[val_wa]   <= val_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    key_q  <= key_mem[cur_r[AW-1:0]];
    val_q  <= val_mem[cur_r[AW-1:0]];
    link_q <= link_mem[cur_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[bkt_r] <= head_wd;
    heads_q <= head_mem[q_bkt];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[sp_r[AW-1:0]] <= cur_r;
    stack_q <= stack_mem[AW'(sp_r - 1'b1)];
  end

  assign out_empty       = !res_valid_r;
  assign out_status      = res_status_r;
  assign out_found_value = res_value_r;

  a_free_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= fresh_r) else $error("free stack deeper than entries handed out");

  a_cmp_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CMP |-> cur_r != NIL) else $error("compare without an entry");

  a_res_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_set |-> !res_valid_r) else $error("result overwritten before pop");

  a_link_after_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_LINK |-> $past(state_r) == B_SLOT || $past(state_r) == B_RD)
    else $error("link without allocation");

endmodule

// ----- src/chained_hash_table_engine_core.sv -----
// top level of the chained hash table engine
// Key-value store with separate chaining. Each beat pushed on the input queue carries an
// opcode (insert, search, delete), a precomputed hash, a key and a value, and produces
// exactly one result beat (status and found value) in request order. The front end takes a
// request and reduces the hash modulo the bucket count, four hash bits per cycle, then
// hands it through a two-entry queue to the sequencer. The sequencer looks up the bucket
// head, then visits each chain entry in turn (registered entry memory read, then key
// compare), and for an insert of a new key takes a slot from the free stack or the fill
// counter and links it in. It takes the next request only after the result beat has been
// popped. The front end and the sequencer each hold one request at a time and work in
// parallel. A result waits in an output register while the front end keeps accepting.
// Freed entries go on a free stack and untouched entries are handed out by a fill counter,
// so no clearing pass is needed after reset. The user must write bucket_count only while
// the block is idle; the block itself does not enforce this.
module chained_hash_table_engine_core #(
  parameter int BUCKETS    = 64,
  parameter int ENTRIES    = 128,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cht_pkg::CFG_W-1:0]    cfg_wr_data,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [cht_pkg::OP_W-1:0]     in_opcode,
  input  logic [cht_pkg::WORD_W-1:0]   in_hash_value,
  input  logic [cht_pkg::WORD_W-1:0]   in_key_word,
  input  logic [cht_pkg::WORD_W-1:0]   in_value_word,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [cht_pkg::STATUS_W-1:0] out_status,
  output logic [cht_pkg::WORD_W-1:0]   out_found_value
);
  import cht_pkg::*;

  // bucket index width, key and value storage widths
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int KW = (KEY_BITS < WORD_W) ? KEY_BITS : WORD_W;
  localparam int VW = (VALUE_BITS < WORD_W) ? VALUE_BITS : WORD_W;
  localparam int QW = OP_W + BW + KW + VW;
  localparam int CAP = (BUCKETS < 127) ? BUCKETS : 127;

  logic [CFG_W-1:0] bucket_count_r;
  logic [CFG_W-1:0] eff_div;
  logic             q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]    q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BUCKET_COUNT_RST;
    end else if (cfg_wr_en) begin
      bucket_count_r <= cfg_wr_data;
    end
  end

  // zero acts as one bucket, anything above the table size saturates
  always_comb begin
    if (bucket_count_r == '0) begin
      eff_div = CFG_W'(1);
    end else if (32'(bucket_count_r) > CAP) begin
      eff_div = CFG_W'(CAP);
    end else begin
      eff_div = bucket_count_r;
    end
  end

  cht_front #(.BW(BW), .KW(KW), .VW(VW)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .div_i         (eff_div),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_opcode     (in_opcode),
    .in_hash_value (in_hash_value),
    .in_key_word   (in_key_word),
    .in_value_word (in_value_word),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_data        (q_wdata)
  );

  cht_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  cht_back #(
    .BUCKETS (BUCKETS),
    .ENTRIES (ENTRIES),
    .BW      (BW),
    .KW      (KW),
    .VW      (VW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (q_rdata),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_found_value (out_found_value)
  );

endmodule

// ----- tb/tb.sv -----
// testbench for the chained hash table engine: directed and random requests against a predictor
`timescale 1ns / 1ps
module tb;
  import cht_pkg::*;

  localparam int NBKT = 64;
  localparam int NENT = 128;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;  // spare opcode, must answer not found
  localparam int NKEYS = 40;

  // expected-result store plus a private copy of the table
  class lookup_scoreboard;
    int unsigned bucket_cfg;
    int unsigned head_of[NBKT];
    logic [WORD_W-1:0] key_of[NENT];
    logic [WORD_W-1:0] val_of[NENT];
    int unsigned next_of[NENT];
    bit busy_slot[NENT];
    logic [STATUS_W-1:0] want_status[$];
    logic [WORD_W-1:0] want_value[$];
    int errors;

    function new();
      bucket_cfg = 64;
      foreach (head_of[i]) head_of[i] = NENT;
      foreach (busy_slot[i]) begin
        busy_slot[i] = 0;
        next_of[i] = NENT;
      end
      errors = 0;
    endfunction

    task report_mismatch(string what);
      $display("%0t mismatch: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return want_status.size();
    endfunction

    // apply one request to the table copy and queue its answer
    function void note(logic [OP_W-1:0] op, logic [WORD_W-1:0] h,
                       logic [WORD_W-1:0] k, logic [WORD_W-1:0] v);
      int unsigned nb, b, cur, prev, hit, steps, slot;
      logic [STATUS_W-1:0] st;
      logic [WORD_W-1:0] fv;
      nb = (bucket_cfg == 0) ? 1 : (bucket_cfg > NBKT) ? NBKT : bucket_cfg;
      b = h % nb;
      cur = head_of[b];
      prev = NENT;
      hit = NENT;
      steps = 0;
      st = ST_NOT_FOUND;
      fv = '0;
      while (cur < NENT && steps < NENT) begin
        if (key_of[cur] == k) begin
          hit = cur;
          break;
        end
        prev = cur;
        cur = next_of[cur];
        steps++;
      end
      case (op)
        OP_INSERT: begin
          if (hit < NENT) begin
            val_of[hit] = v;
            st = ST_UPDATED;
          end else begin
            slot = NENT;
            for (int i = 0; i < NENT; i++)
              if (!busy_slot[i]) begin
                slot = i;
                break;
              end
            if (slot < NENT) begin
              key_of[slot] = k;
              val_of[slot] = v;
              next_of[slot] = head_of[b];
              busy_slot[slot] = 1;
              head_of[b] = slot;
              st = ST_INSERTED;
            end else st = ST_POOL_FULL;
          end
        end
        OP_SEARCH: begin
          if (hit < NENT) begin
            st = ST_FOUND;
            fv = val_of[hit];
          end
        end
        OP_DELETE: begin
          if (hit < NENT) begin
            if (prev < NENT) next_of[prev] = next_of[hit];
            else head_of[b] = next_of[hit];
            busy_slot[hit] = 0;
            st = ST_DELETED;
          end
        end
        default: ;
      endcase
      want_status.push_back(st);
      want_value.push_back(fv);
    endfunction

    task check(logic [STATUS_W-1:0] st, logic [WORD_W-1:0] fv);
      logic [STATUS_W-1:0] es;
      logic [WORD_W-1:0] ev;
      if (want_status.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d", st));
      end else begin
        es = want_status.pop_front();
        ev = want_value.pop_front();
        if (st !== es) report_mismatch($sformatf("status %0d, want %0d", st, es));
        if (fv !== ev) report_mismatch($sformatf("found_value %h, want %h", fv, ev));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [OP_W-1:0] in_opcode = '0;
  logic [WORD_W-1:0] in_hash_value = '0;
  logic [WORD_W-1:0] in_key_word = '0;
  logic [WORD_W-1:0] in_value_word = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [WORD_W-1:0] out_found_value;

  lookup_scoreboard sb = new();
  bit calm = 0;            // no idling on either side while set
  int hold_left = 0;       // receiver hold-off cycles still to go
  logic [WORD_W-1:0] key_pool[NKEYS];

  chained_hash_table_engine_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_push(in_push), .in_full(in_full),
    .in_opcode(in_opcode), .in_hash_value(in_hash_value),
    .in_key_word(in_key_word), .in_value_word(in_value_word),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_status(out_status), .out_found_value(out_found_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random pops, plus a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop = 1'b0;
      end else out_pop = calm || ($urandom_range(99) >= 15);
      @(posedge clk);
      if (out_pop && !out_empty) sb.check(out_status, out_found_value);
    end
  end

  // hash tied to the key, so repeated keys usually land in the same bucket
  function automatic logic [WORD_W-1:0] key_hash(logic [WORD_W-1:0] k);
    return (k * 32'h9E37_79B1) ^ (k >> 13);
  endfunction

  // offer one request beat, held until accepted; called right after a falling edge
  task send_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] h,
                    logic [WORD_W-1:0] k, logic [WORD_W-1:0] v);
    while (!calm && $urandom_range(99) < 15) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_opcode = op;
    in_hash_value = h;
    in_key_word = k;
    in_value_word = v;
    forever begin
      @(posedge clk);
      if (!in_full) break;
    end
    sb.note(op, h, k, v);
    @(negedge clk);
    in_push = 1'b0;
  endtask

  // random request over the small key pool; weights favor hits
  task send_mixed();
    int r;
    logic [OP_W-1:0] op;
    logic [WORD_W-1:0] k, h;
    r = $urandom_range(99);
    op = (r < 45) ? OP_INSERT : (r < 70) ? OP_SEARCH : (r < 95) ? OP_DELETE : OP_UNUSED;
    k = key_pool[$urandom_range(NKEYS - 1)];
    h = ($urandom_range(99) < 85) ? key_hash(k) : $urandom;
    send_request(op, h, k, $urandom);
  endtask

  // bucket count only changes once the block has drained
  task set_buckets(logic [CFG_W-1:0] n);
    while (sb.pending() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = n;
    sb.bucket_cfg = n;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    logic [WORD_W-1:0] fresh;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: field extremes, hits, misses, update, spare opcode, shared bucket
    send_request(OP_INSERT, '0, '0, '0);
    send_request(OP_INSERT, '1, '1, '1);
    send_request(OP_SEARCH, '0, '0, 32'h1234_5678);
    send_request(OP_SEARCH, '1, '1, '0);
    send_request(OP_INSERT, '0, '0, 32'hA5A5_5A5A);
    send_request(OP_SEARCH, '0, '0, '0);
    send_request(OP_INSERT, 32'd64, 32'h0000_0077, 32'h5555_AAAA);  // same bucket as key 0
    send_request(OP_SEARCH, 32'd128, 32'h0000_0077, '0);
    send_request(OP_DELETE, '0, '0, '0);
    send_request(OP_DELETE, '0, '0, '0);
    send_request(OP_SEARCH, '0, '0, '0);
    send_request(OP_SEARCH, 32'd64, 32'h0000_0077, '0);
    send_request(OP_UNUSED, '0, 32'h0000_0077, '1);
    send_request(OP_DELETE, 32'd5, 32'hDEAD_BEEF, '0);
    send_request(OP_UNUSED, '1, '1, '1);

    // one bucket: everything on a single chain, receiver stalls to back up the input
    set_buckets(7'd1);
    hold_left = 300;
    repeat (150) send_mixed();

    // zero behaves as one bucket
    set_buckets(7'd0);
    repeat (80) send_mixed();

    // above the maximum saturates; exhaust the pool with fresh keys
    set_buckets(7'd127);
    repeat (150) begin
      fresh = $urandom;
      send_request(OP_INSERT, key_hash(fresh), fresh, $urandom);
    end
    repeat (60) send_mixed();

    // odd bucket count, back to back on both sides
    set_buckets(7'd7);
    calm = 1;
    repeat (150) send_mixed();
    calm = 0;

    set_buckets(7'd64);
    repeat (100) send_mixed();

    while (sb.pending() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (sb.pending() != 0) sb.report_mismatch("results still outstanding");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
